// File: hdl/chp_pkg.sv
// Shared types for the chunk header parser: cache entry and result record.
// No dependencies; every other file in hdl imports this package.
`default_nettype none

package chp_pkg;

  // One cache entry per chunk stream.
  typedef struct packed {
    logic [31:0] ts;
    logic [23:0] len;
    logic [7:0]  typ;
    logic [31:0] ms;
  } entry_t;

  // One result record.
  typedef struct packed {
    logic        status;
    logic [16:0] id;
    logic [1:0]  fmt;
    logic [31:0] ts;
    logic [23:0] len;
    logic [7:0]  typ;
    logic [31:0] ms;
  } res_t;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_ID_HIGH = 1'b1;

endpackage

`default_nettype wire

// File: hdl/chp_cache.sv
// Per-stream header cache: single-write, single-read memory with registered read,
// same-edge write bypass and a clearing sweep after reset. Depends on chp_pkg.
`default_nettype none

module chp_cache #(
  parameter int CACHE_DEPTH = 64,
  localparam int AW = $clog2(CACHE_DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire chp_pkg::entry_t wr_data,
  output chp_pkg::entry_t      rd_data,
  output logic                 clr_busy
);
  import chp_pkg::*;

  entry_t          mem [CACHE_DEPTH];
  entry_t          q_r;
  entry_t          byp_data_r;
  logic            byp_r;
  logic            clr_r;
  logic [AW-1:0]   clr_cnt_r;
  logic            we;
  logic [AW-1:0]   wa;
  entry_t          wd;

  // Sweep zeros into every entry after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      if (clr_cnt_r == AW'(CACHE_DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_comb begin
    we = wr_en;
    wa = wr_addr;
    wd = wr_data;
    if (clr_r) begin
      we = 1'b1;
      wa = clr_cnt_r;
      wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // Read and write of one entry at the same edge: take the new data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= rd_en && we && (rd_addr == wa);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data_r <= wd;
    end
  end

  assign rd_data  = byp_r ? byp_data_r : q_r;
  assign clr_busy = clr_r;

endmodule

`default_nettype wire

// File: hdl/chp_parse.sv
// Byte parser: basic and message header fields, cache read on id completion,
// merge and write-back from the registered command of the closing byte. Depends on chp_pkg.
`default_nettype none

module chp_parse #(
  parameter int CACHE_DEPTH = 64,
  localparam int AW = $clog2(CACHE_DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_hdr_byte,
  input  wire logic            clr_busy,
  input  wire chp_pkg::entry_t rd_data,
  input  wire logic            out_can,
  output logic                 rd_en,
  output logic [AW-1:0]        rd_addr,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output chp_pkg::entry_t      wr_data,
  output logic                 res_valid,
  output chp_pkg::res_t        res
);
  import chp_pkg::*;

  typedef enum logic [9:0] {
    PH_BASIC  = 10'b00_0000_0001,
    PH_ID2    = 10'b00_0000_0010,
    PH_ID3A   = 10'b00_0000_0100,
    PH_ID3B   = 10'b00_0000_1000,
    PH_TS     = 10'b00_0001_0000,
    PH_LEN    = 10'b00_0010_0000,
    PH_TYPE   = 10'b00_0100_0000,
    PH_MS     = 10'b00_1000_0000,
    PH_EXT    = 10'b01_0000_0000,
    PH_F3WAIT = 10'b10_0000_0000
  } phase_t;

  typedef enum logic [3:0] {
    CMD_NONE = 4'b0001,
    CMD_ERR  = 4'b0010,
    CMD_F3   = 4'b0100,
    CMD_FIN  = 4'b1000
  } cmd_t;

  localparam logic [31:0] EXT_MARK = 32'h00FF_FFFF;
  localparam logic [16:0] ID_BASE  = 17'd64;
  localparam logic [1:0]  FMT_FULL = 2'd0;
  localparam logic [1:0]  FMT_NOID = 2'd1;
  localparam logic [1:0]  FMT_DLT  = 2'd2;

  phase_t      phase_r, phase_nxt, phase_eff;
  cmd_t        cmd_r, cmd_nxt;
  logic [1:0]  fmt_r, fmt_nxt;
  logic [16:0] id_r, id_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] tf_r, tf_nxt;
  entry_t      ent_r, ent_nxt;
  logic        load_r;

  entry_t      view;
  logic        mark_hit;
  logic        finish;
  logic        stall;
  logic        accept;
  logic [31:0] ts_merge;

  // Entry just read from the cache, or the working copy.
  assign view     = load_r ? rd_data : ent_r;
  assign mark_hit = (view.ts == EXT_MARK);
  assign phase_eff = (phase_r == PH_F3WAIT) ? (mark_hit ? PH_EXT : PH_BASIC) : phase_r;

  // Result side: one command from the previous transfer.
  always_comb begin
    res_valid = 1'b0;
    finish    = 1'b0;
    res       = '0;
    res.id    = id_r;
    res.fmt   = fmt_r;
    ts_merge  = (fmt_r == FMT_FULL) ? tf_r : view.ts + tf_r;
    case (cmd_r)
      CMD_ERR: begin
        res_valid  = 1'b1;
        res.status = STATUS_ID_HIGH;
      end
      CMD_F3: begin
        finish = !mark_hit;
      end
      CMD_FIN: begin
        finish = 1'b1;
      end
      default: begin
        finish = 1'b0;
      end
    endcase
    if (finish) begin
      res_valid  = 1'b1;
      res.status = STATUS_OK;
      res.ts     = ts_merge;
      res.len    = view.len;
      res.typ    = view.typ;
      res.ms     = view.ms;
    end
  end

  assign stall    = res_valid && !out_can;
  assign wr_en    = finish && !stall;
  assign wr_addr  = id_r[AW-1:0];
  assign wr_data  = '{ts: ts_merge, len: view.len, typ: view.typ, ms: view.ms};
  assign in_ready = !clr_busy && !stall;
  assign accept   = in_valid && in_ready;

  // Byte side.
  always_comb begin
    logic [31:0] acc_sh;
    logic [31:0] acc_or;
    logic        id_done;
    logic        ext_chk;
    logic [31:0] ext_val;

    phase_nxt = phase_eff;
    cmd_nxt   = stall ? cmd_r : CMD_NONE;
    fmt_nxt   = fmt_r;
    id_nxt    = id_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    tf_nxt    = tf_r;
    ent_nxt   = view;
    rd_en     = 1'b0;
    rd_addr   = '0;
    id_done   = 1'b0;
    ext_chk   = 1'b0;
    ext_val   = tf_r;
    acc_sh    = {acc_r[23:0], in_hdr_byte};
    acc_or    = acc_r | (32'(in_hdr_byte) << {cnt_r, 3'b000});

    if (accept) begin
      case (phase_eff)
        PH_BASIC: begin
          fmt_nxt = in_hdr_byte[7:6];
          if (in_hdr_byte[5:1] != 5'd0) begin
            id_nxt  = {11'd0, in_hdr_byte[5:0]};
            id_done = 1'b1;
          end else begin
            id_nxt    = '0;
            phase_nxt = in_hdr_byte[0] ? PH_ID3A : PH_ID2;
          end
        end
        PH_ID2: begin
          id_nxt  = {9'd0, in_hdr_byte} + ID_BASE;
          id_done = 1'b1;
        end
        PH_ID3A: begin
          id_nxt    = {9'd0, in_hdr_byte};
          phase_nxt = PH_ID3B;
        end
        PH_ID3B: begin
          id_nxt  = id_r + {1'b0, in_hdr_byte, 8'd0} + ID_BASE;
          id_done = 1'b1;
        end
        PH_TS: begin
          if (cnt_r != 2'd2) begin
            acc_nxt = acc_sh;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            tf_nxt  = {8'd0, acc_sh[23:0]};
            acc_nxt = '0;
            cnt_nxt = '0;
            if (fmt_r == FMT_FULL || fmt_r == FMT_NOID) begin
              phase_nxt = PH_LEN;
            end else begin
              ext_chk = 1'b1;
              ext_val = {8'd0, acc_sh[23:0]};
            end
          end
        end
        PH_LEN: begin
          if (cnt_r != 2'd2) begin
            acc_nxt = acc_sh;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ent_nxt.len = acc_sh[23:0];
            acc_nxt     = '0;
            cnt_nxt     = '0;
            phase_nxt   = PH_TYPE;
          end
        end
        PH_TYPE: begin
          ent_nxt.typ = in_hdr_byte;
          if (fmt_r == FMT_FULL) begin
            acc_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_MS;
          end else begin
            ext_chk = 1'b1;
          end
        end
        PH_MS: begin
          if (cnt_r != 2'd3) begin
            acc_nxt = acc_or;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ent_nxt.ms = acc_or;
            acc_nxt    = '0;
            cnt_nxt    = '0;
            ext_chk    = 1'b1;
          end
        end
        PH_EXT: begin
          if (cnt_r != 2'd3) begin
            acc_nxt = acc_sh;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            tf_nxt    = acc_sh;
            acc_nxt   = '0;
            cnt_nxt   = '0;
            phase_nxt = PH_BASIC;
            cmd_nxt   = CMD_FIN;
          end
        end
        default: begin
          phase_nxt = PH_BASIC;
        end
      endcase

      // Basic header complete: range check, then fetch the stream's entry.
      if (id_done) begin
        if (id_nxt >= 17'(CACHE_DEPTH)) begin
          phase_nxt = PH_BASIC;
          cmd_nxt   = CMD_ERR;
        end else begin
          rd_en   = 1'b1;
          rd_addr = id_nxt[AW-1:0];
          acc_nxt = '0;
          tf_nxt  = '0;
          cnt_nxt = '0;
          if (fmt_nxt == FMT_FULL || fmt_nxt == FMT_NOID || fmt_nxt == FMT_DLT) begin
            phase_nxt = PH_TS;
          end else begin
            phase_nxt = PH_F3WAIT;
            cmd_nxt   = CMD_F3;
          end
        end
      end

      // Extended timestamp follows, or the header is done.
      if (ext_chk) begin
        if (ext_val == EXT_MARK) begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          phase_nxt = PH_EXT;
        end else begin
          phase_nxt = PH_BASIC;
          cmd_nxt   = CMD_FIN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_BASIC;
      cmd_r   <= CMD_NONE;
      load_r  <= 1'b0;
      fmt_r   <= '0;
      id_r    <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      tf_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      load_r  <= rd_en;
      fmt_r   <= fmt_nxt;
      id_r    <= id_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      tf_r    <= tf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/chp_out.sv
// Result output register: holds one result until the consumer takes it.
// Depends on chp_pkg for the result record.
`default_nettype none

module chp_out (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_valid,
  input  wire chp_pkg::res_t res,
  output logic               out_can,
  output logic               out_valid,
  input  wire logic          out_ready,
  output chp_pkg::res_t      out_res
);
  import chp_pkg::*;

  logic out_valid_r;
  res_t res_r;

  assign out_can = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && out_can) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_can) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// File: hdl/chunk_header_parser_top.sv
// Top level of the chunk header parser: byte parser, stream cache, output register.
// Depends on chp_pkg, chp_cache, chp_parse and chp_out.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_hdr_byte[7:0]
//   out      output     out_valid/out_ready  status, id, format, timestamp,
//                                            length, type, message stream
//
// One header byte is taken per cycle while in_ready is high. A result is formed
// from the registered command of the byte that closes its header (or its basic
// header, for an id beyond the cache), merged with the cache entry, and then
// held in the output register. The cache is one memory port pair; its entry is
// fetched when the id completes. After reset the cache is swept to zero, with
// in_ready low. Apart from the sweep, in_ready drops only while a result cannot
// move into a full output register that the consumer is holding.
`default_nettype none

module chunk_header_parser_top #(
  parameter int CACHE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_hdr_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_status,
  output logic [16:0]      out_chunk_id,
  output logic [1:0]       out_header_format,
  output logic [31:0]      out_abs_timestamp,
  output logic [23:0]      out_msg_length,
  output logic [7:0]       out_msg_type,
  output logic [31:0]      out_msg_stream
);
  import chp_pkg::*;

  localparam int AW = $clog2(CACHE_DEPTH);

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  logic          clr_busy;
  logic          res_valid;
  res_t          res;
  logic          out_can;
  res_t          out_res;

  // Stream cache: entry fetch on id, write-back on header completion.
  chp_cache #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_cache (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  // Parser: one transfer a cycle, hold while a result waits on a full output or the cache is swept.
  chp_parse #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_hdr_byte (in_hdr_byte),
    .clr_busy    (clr_busy),
    .rd_data     (rd_data),
    .out_can     (out_can),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register parts the parser from the consumer.
  chp_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_can   (out_can),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_chunk_id      = out_res.id;
  assign out_header_format = out_res.fmt;
  assign out_abs_timestamp = out_res.ts;
  assign out_msg_length    = out_res.len;
  assign out_msg_type      = out_res.typ;
  assign out_msg_stream    = out_res.ms;

endmodule

`default_nettype wire
